### design/gbr_pkg.sv
// ----------------------------------------------------------------------------
// gbr_pkg
// Shared types, constants and the weight table for the band resampler.
// ----------------------------------------------------------------------------
package gbr_pkg;

   localparam int MAX_BANDS          = 256;
   localparam int WEIGHT_TABLE_DEPTH = 256;

   localparam int IDX_W   = $clog2(MAX_BANDS);
   localparam int CNT_W   = IDX_W + 1;
   localparam int WL_W    = 20;
   localparam int SMP_W   = 24;
   localparam int FW_W    = 16;
   localparam int TAB_W   = $clog2(WEIGHT_TABLE_DEPTH);
   localparam int WT_W    = 17;
   localparam int SHIFT_LIMIT = 17;
   localparam int QLIM    = SHIFT_LIMIT * WEIGHT_TABLE_DEPTH;
   localparam int Q_W     = $clog2(QLIM);
   localparam int DSQ_W   = 2 * WL_W;
   localparam int WNUM_W  = DSQ_W + 2 + TAB_W;
   localparam int FSQ_W   = 2 * FW_W;
   localparam int NUM_W   = SMP_W + WT_W + CNT_W;
   localparam int DEN_W   = WT_W + IDX_W;
   localparam int STEP_W  = $clog2(NUM_W + 1);
   localparam int SPAN_KW = 17;
   localparam int SPAN_W  = FW_W + SPAN_KW;
   localparam int RNG_W   = WL_W + 16;

   localparam logic [SPAN_KW-1:0] SPAN_K = SPAN_KW'(83493);
   localparam logic [63:0] LN2_Q30 = 64'd744261118;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;

   localparam logic [SMP_W-1:0] RES_MAX_POS = {1'b0, {(SMP_W-1){1'b1}}};
   localparam logic [SMP_W-1:0] RES_MAX_NEG = {1'b1, {(SMP_W-1){1'b0}}};

   typedef struct packed {
      logic                    operation;
      logic                    first_band;
      logic [WL_W-1:0]         band_wavelength;
      logic signed [SMP_W-1:0] sample_value;
      logic [WL_W-1:0]         center_wavelength;
      logic [FW_W-1:0]         fwhm_width;
   } gbr_req_type;

   typedef struct packed {
      logic signed [SMP_W-1:0] result_value;
      logic                    in_range;
   } gbr_rsp_type;

   // front to back command
   typedef struct packed {
      logic                    is_query;
      logic                    wr_en;
      logic [IDX_W-1:0]        wr_idx;
      logic [WL_W-1:0]         wl;
      logic signed [SMP_W-1:0] sample;
      logic [WL_W-1:0]         center;
      logic [FW_W-1:0]         fwhm;
      logic [CNT_W-1:0]        count;
      logic                    pass;
   } gbr_cmd_type;

   typedef logic [WT_W-1:0] gbr_wtab_type [WEIGHT_TABLE_DEPTH];

   function automatic logic [63:0] series_mul(input logic [63:0] term, input logic [63:0] y);
      return (term * y) >> 30;
   endfunction

   // 2^(-r/DEPTH) in Q16 via truncated exp series
   function automatic logic [WT_W-1:0] wt_entry(input int unsigned r);
      logic [63:0] y;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      y    = (64'(r) * LN2_Q30) / WEIGHT_TABLE_DEPTH;
      pos  = ONE_Q30;
      neg  = 64'd0;
      term = series_mul(ONE_Q30, y) / 1;  neg = neg + term;
      term = series_mul(term, y) / 2;     pos = pos + term;
      term = series_mul(term, y) / 3;     neg = neg + term;
      term = series_mul(term, y) / 4;     pos = pos + term;
      term = series_mul(term, y) / 5;     neg = neg + term;
      term = series_mul(term, y) / 6;     pos = pos + term;
      term = series_mul(term, y) / 7;     neg = neg + term;
      term = series_mul(term, y) / 8;     pos = pos + term;
      term = series_mul(term, y) / 9;     neg = neg + term;
      term = series_mul(term, y) / 10;    pos = pos + term;
      term = series_mul(term, y) / 11;    neg = neg + term;
      term = series_mul(term, y) / 12;    pos = pos + term;
      term = series_mul(term, y) / 13;    neg = neg + term;
      return WT_W'(((pos - neg) + 64'd8192) >> 14);
   endfunction

   function automatic gbr_wtab_type build_wtab();
      gbr_wtab_type t;
      for (int unsigned r = 0; r < WEIGHT_TABLE_DEPTH; r++) begin
         t[r] = wt_entry(r);
      end
      return t;
   endfunction

   localparam gbr_wtab_type WTAB = build_wtab();

endpackage

### design/gaussian_band_resampler.sv
// ----------------------------------------------------------------------------
// gaussian_band_resampler
// Gaussian FWHM spectral resampling of one loaded spectrum.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries loads (operation 0) and queries (operation 1). A load with
//   first_band set starts a new spectrum. Loads give no response; each query
//   gives one response on rsp_* with the weighted mean and in_range.
//   Requests pass through a four-entry queue into the execution unit, so the
//   front keeps accepting while the back is busy, until the queue fills.
//   A load is written to the band store when the back takes it. A query
//   walks every stored band in turn (memory read, distance square, serial
//   weight divide, table lookup, multiply, accumulate; divide and lookup
//   are skipped when the weight is zero), then runs a serial final divide.
//   Out-of-range queries go straight to the response.
//   The result sits in an output register; a stalled receiver holds it and
//   the back waits only when the next result is ready.
//   Reset empties the queue and the spectrum: band count zero, limits
//   cleared.
// ----------------------------------------------------------------------------
module gaussian_band_resampler
   import gbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  gbr_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output gbr_rsp_type rsp_data
);

   logic        q_full, q_push, q_empty, q_pop;
   gbr_cmd_type push_cmd, head_cmd;

   gbr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   gbr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_cmd (head_cmd)
   );

   gbr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_cmd     (head_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### design/gbr_front.sv
// ----------------------------------------------------------------------------
// gbr_front
// Accepts requests, tracks band count and wavelength limits, prechecks
// query range and issues commands to the queue.
// ----------------------------------------------------------------------------
module gbr_front
   import gbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  gbr_req_type req_data,
   input  logic        q_full,
   output logic        q_push,
   output gbr_cmd_type q_cmd
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [WL_W-1:0]  low_ff, low_in;
   logic [WL_W-1:0]  high_ff, high_in;

   logic [CNT_W-1:0] eff_count;
   logic [WL_W-1:0]  eff_low, eff_high;
   logic             has_room;
   logic [SPAN_W-1:0] span;
   logic [RNG_W-1:0]  lo_gap, hi_gap;
   logic              pass;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      eff_count = req_data.first_band ? '0 : count_ff;
      eff_low   = req_data.first_band ? '1 : low_ff;
      eff_high  = req_data.first_band ? '0 : high_ff;
      has_room  = eff_count < CNT_W'(MAX_BANDS);
      count_in  = count_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      if (q_push && !req_data.operation) begin
         count_in = eff_count;
         low_in   = eff_low;
         high_in  = eff_high;
         if (has_room) begin
            count_in = eff_count + CNT_W'(1);
            if (req_data.band_wavelength < eff_low)  low_in  = req_data.band_wavelength;
            if (req_data.band_wavelength > eff_high) high_in = req_data.band_wavelength;
         end
      end
   end

   always_comb begin
      span   = SPAN_W'(req_data.fwhm_width) * SPAN_W'(SPAN_K);
      lo_gap = {req_data.center_wavelength - low_ff, 16'd0};
      hi_gap = {high_ff - req_data.center_wavelength, 16'd0};
      pass   = (count_ff != '0) && (req_data.fwhm_width != '0) &&
               (req_data.center_wavelength >= low_ff) &&
               (req_data.center_wavelength <= high_ff) &&
               (lo_gap >= RNG_W'(span)) && (hi_gap >= RNG_W'(span));
   end

   always_comb begin
      q_cmd.is_query = req_data.operation;
      q_cmd.wr_en    = has_room;
      q_cmd.wr_idx   = eff_count[IDX_W-1:0];
      q_cmd.wl       = req_data.band_wavelength;
      q_cmd.sample   = req_data.sample_value;
      q_cmd.center   = req_data.center_wavelength;
      q_cmd.fwhm     = req_data.fwhm_width;
      q_cmd.count    = count_ff;
      q_cmd.pass     = pass;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         low_ff   <= '1;
         high_ff  <= '0;
      end else begin
         count_ff <= count_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
      end
   end

endmodule

### design/gbr_queue.sv
// ----------------------------------------------------------------------------
// gbr_queue
// Four-entry command queue between front and back.
// ----------------------------------------------------------------------------
module gbr_queue
   import gbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  gbr_cmd_type push_cmd,
   output logic        full,
   input  logic        pop,
   output logic        empty,
   output gbr_cmd_type head_cmd
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   gbr_cmd_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     fill_ff, fill_in;

   assign full     = fill_ff == (PTR_W+1)'(DEPTH);
   assign empty    = fill_ff == '0;
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### design/gbr_back.sv
// ----------------------------------------------------------------------------
// gbr_back
// Executes commands: stores bands, walks stored bands per query with a
// serial weight divider and a multiply-accumulate, then a serial final
// divide, and holds the response register.
// ----------------------------------------------------------------------------
module gbr_back
   import gbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  gbr_cmd_type q_cmd,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output gbr_rsp_type rsp_data
);

   typedef enum logic [11:0] {
      ST_IDLE = 12'b0000_0000_0001,
      ST_FSQ  = 12'b0000_0000_0010,
      ST_READ = 12'b0000_0000_0100,
      ST_DIST = 12'b0000_0000_1000,
      ST_CHK  = 12'b0000_0001_0000,
      ST_WDIV = 12'b0000_0010_0000,
      ST_WT   = 12'b0000_0100_0000,
      ST_MUL  = 12'b0000_1000_0000,
      ST_ACC  = 12'b0001_0000_0000,
      ST_FIN  = 12'b0010_0000_0000,
      ST_QDIV = 12'b0100_0000_0000,
      ST_DONE = 12'b1000_0000_0000
   } gbr_state_type;

   gbr_state_type state_ff, state_in;

   logic [WL_W-1:0]         mem_wl  [MAX_BANDS];
   logic signed [SMP_W-1:0] mem_smp [MAX_BANDS];
   logic [WL_W-1:0]         rd_wl_ff;
   logic signed [SMP_W-1:0] rd_smp_ff;

   logic [WL_W-1:0]         center_ff;
   logic [FW_W-1:0]         fwhm_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        idx_ff;
   logic [FSQ_W-1:0]        fsq_ff;
   logic [DSQ_W-1:0]        dsq_ff;
   logic [FSQ_W-1:0]        wrem_ff;
   logic [Q_W-1:0]          wq_ff;
   logic [WT_W-1:0]         w_ff;
   logic signed [WT_W+SMP_W:0] prod_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [DEN_W-1:0]        qrem_ff;
   logic [NUM_W-1:0]        dq_ff;
   logic                    neg_ff;
   logic                    ok_ff;
   logic [STEP_W-1:0]       step_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   gbr_rsp_type             rsp_data_ff;

   logic [WL_W-1:0]   gap_wl;
   logic [WNUM_W-1:0] wnum, thr;
   logic [FSQ_W:0]    wt;
   logic              wbit;
   logic [DEN_W:0]    qt;
   logic              qbit;
   logic [NUM_W-1:0]  mag;
   logic              out_free;
   logic              fire;
   logic [SMP_W-1:0]  sat;
   logic [CNT_W-1:0]  idx_next;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = (state_ff == ST_DONE) && out_free;
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign idx_next  = idx_ff + CNT_W'(1);

   always_comb begin
      gap_wl = (rd_wl_ff > center_ff) ? rd_wl_ff - center_ff : center_ff - rd_wl_ff;
      wnum = {dsq_ff, (2+TAB_W)'(0)};
      thr  = WNUM_W'(fsq_ff) * WNUM_W'(QLIM);
      wt   = {wrem_ff, wq_ff[Q_W-1]};
      wbit = wt >= {1'b0, fsq_ff};
      qt   = {qrem_ff, dq_ff[NUM_W-1]};
      qbit = qt >= {1'b0, den_ff};
      mag  = (num_ff < 0) ? NUM_W'(-num_ff) : NUM_W'(num_ff);
      mag  = mag + NUM_W'(den_ff >> 1);
      if (neg_ff) begin
         sat = (dq_ff > NUM_W'(RES_MAX_NEG)) ? RES_MAX_NEG : SMP_W'(-dq_ff);
      end else begin
         sat = (dq_ff > NUM_W'(RES_MAX_POS)) ? RES_MAX_POS : dq_ff[SMP_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (!q_empty && q_cmd.is_query) state_in = q_cmd.pass ? ST_FSQ : ST_DONE;
         ST_FSQ:  state_in = ST_READ;
         ST_READ: state_in = ST_DIST;
         ST_DIST: state_in = ST_CHK;
         ST_CHK:  state_in = (wnum >= thr) ? ST_MUL : ST_WDIV;
         ST_WDIV: if (step_ff == STEP_W'(Q_W-1)) state_in = ST_WT;
         ST_WT:   state_in = ST_MUL;
         ST_MUL:  state_in = ST_ACC;
         ST_ACC:  state_in = (idx_next == count_ff) ? ST_FIN : ST_READ;
         ST_FIN:  state_in = (den_ff == '0) ? ST_DONE : ST_QDIV;
         ST_QDIV: if (step_ff == STEP_W'(NUM_W-1)) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // band store
   always_ff @(posedge clock) begin
      if (q_pop && !q_cmd.is_query && q_cmd.wr_en) begin
         mem_wl[q_cmd.wr_idx]  <= q_cmd.wl;
         mem_smp[q_cmd.wr_idx] <= q_cmd.sample;
      end
      rd_wl_ff  <= mem_wl[idx_ff[IDX_W-1:0]];
      rd_smp_ff <= mem_smp[idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            center_ff <= q_cmd.center;
            fwhm_ff   <= q_cmd.fwhm;
            count_ff  <= q_cmd.count;
            idx_ff    <= '0;
            num_ff    <= '0;
            den_ff    <= '0;
            ok_ff     <= q_cmd.pass;
            neg_ff    <= 1'b0;
            dq_ff     <= '0;
         end
         ST_FSQ:  fsq_ff <= FSQ_W'(fwhm_ff) * FSQ_W'(fwhm_ff);
         ST_DIST: dsq_ff <= DSQ_W'(gap_wl) * DSQ_W'(gap_wl);
         ST_CHK: begin
            w_ff    <= '0;
            wrem_ff <= FSQ_W'(wnum >> Q_W);
            wq_ff   <= wnum[Q_W-1:0];
            step_ff <= '0;
         end
         ST_WDIV: begin
            wrem_ff <= wbit ? FSQ_W'(wt - {1'b0, fsq_ff}) : wt[FSQ_W-1:0];
            wq_ff   <= {wq_ff[Q_W-2:0], wbit};
            step_ff <= step_ff + STEP_W'(1);
         end
         ST_WT:   w_ff <= WTAB[wq_ff[TAB_W-1:0]] >> wq_ff[Q_W-1:TAB_W];
         ST_MUL:  prod_ff <= $signed({1'b0, w_ff}) * rd_smp_ff;
         ST_ACC: begin
            num_ff <= num_ff + NUM_W'(prod_ff);
            den_ff <= den_ff + DEN_W'(w_ff);
            idx_ff <= idx_next;
         end
         ST_FIN: begin
            ok_ff   <= den_ff != '0;
            neg_ff  <= num_ff < 0;
            dq_ff   <= mag;
            qrem_ff <= '0;
            step_ff <= '0;
         end
         ST_QDIV: begin
            qrem_ff <= qbit ? DEN_W'(qt - {1'b0, den_ff}) : qt[DEN_W-1:0];
            dq_ff   <= {dq_ff[NUM_W-2:0], qbit};
            step_ff <= step_ff + STEP_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff.result_value <= ok_ff ? sat : '0;
         rsp_data_ff.in_range     <= ok_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire)           rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/gbr_checker.sv
// ----------------------------------------------------------------------------
// gbr_checker
// Port-level checks for the band resampler.
// ----------------------------------------------------------------------------
module gbr_checker
   import gbr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input gbr_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input gbr_rsp_type rsp_data
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request dropped or changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response changed while stalled");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.in_range |-> rsp_data.result_value == '0)
      else $error("invalid response carries nonzero value");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind gaussian_band_resampler gbr_checker u_gbr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### dv/gbr_checker.sv
// ----------------------------------------------------------------------------
// gbr_scoreboard
// Watches the request and response channels of the band resampler, keeps its
// own copy of the loaded spectrum, computes the expected weighted mean for
// each query and compares it with each response in order.
// ----------------------------------------------------------------------------
module gbr_scoreboard
   import gbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  gbr_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  gbr_rsp_type rsp_data,
   output int          fail_count,
   output int          pending_count
);

   logic [31:0]             wtab_q16 [WEIGHT_TABLE_DEPTH];
   logic [WL_W-1:0]         spec_wl [MAX_BANDS];
   logic signed [SMP_W-1:0] spec_smp [MAX_BANDS];
   int unsigned             spec_count;
   logic [WL_W-1:0]         spec_lo;
   logic [WL_W-1:0]         spec_hi;
   gbr_rsp_type             mean_queue [$];

   function automatic logic [31:0] pow2_neg(input int unsigned r);
      logic [63:0] y, term, pos, neg;
      y = (64'(r) * 64'd744261118) / WEIGHT_TABLE_DEPTH;
      term = 64'd1073741824;
      pos = term;
      neg = 0;
      for (int k = 1; k <= 13; k++) begin
         term = ((term * y) >> 30) / k;
         if (k % 2) neg += term; else pos += term;
      end
      return 32'(((pos - neg) + 64'd8192) >> 14);
   endfunction

   function automatic gbr_rsp_type resample_band(input logic [WL_W-1:0] c,
                                                 input logic [FW_W-1:0] f);
      gbr_rsp_type res;
      logic ok;
      logic [63:0] span, d, q, w, den, mag, qt;
      longint num;
      res = '0;
      ok = spec_count > 0 && f != 0 && c >= spec_lo && c <= spec_hi;
      if (ok) begin
         span = 64'(f) * 64'd83493;
         ok = (64'(c - spec_lo) << 16) >= span && (64'(spec_hi - c) << 16) >= span;
      end
      num = 0;
      den = 0;
      if (ok) begin
         for (int i = 0; i < spec_count; i++) begin
            d = spec_wl[i] > c ? 64'(spec_wl[i] - c) : 64'(c - spec_wl[i]);
            q = (4 * d * d * WEIGHT_TABLE_DEPTH) / (64'(f) * 64'(f));
            if (q / WEIGHT_TABLE_DEPTH >= 17) w = 0;
            else w = 64'(wtab_q16[q % WEIGHT_TABLE_DEPTH]) >> (q / WEIGHT_TABLE_DEPTH);
            num += longint'(w) * longint'(spec_smp[i]);
            den += w;
         end
         ok = den != 0;
      end
      if (ok) begin
         mag = num < 0 ? 64'(-num) : 64'(num);
         qt = (mag + den / 2) / den;
         if (num < 0) res.result_value = qt > 8388608 ? -24'sd8388608 : -24'(qt);
         else res.result_value = qt > 8388607 ? 24'sd8388607 : 24'(qt);
      end
      res.in_range = ok;
      return res;
   endfunction

   initial begin
      for (int r = 0; r < WEIGHT_TABLE_DEPTH; r++) wtab_q16[r] = pow2_neg(r);
   end

   always @(posedge clock) begin
      gbr_rsp_type exp_rsp;
      if (reset) begin
         spec_count <= 0;
         spec_lo <= '1;
         spec_hi <= '0;
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_data.operation == 1'b0) begin
               automatic int unsigned n = req_data.first_band ? 0 : spec_count;
               automatic logic [WL_W-1:0] lo = req_data.first_band ? '1 : spec_lo;
               automatic logic [WL_W-1:0] hi = req_data.first_band ? '0 : spec_hi;
               if (n < MAX_BANDS) begin
                  spec_wl[n] = req_data.band_wavelength;
                  spec_smp[n] = req_data.sample_value;
                  n++;
                  if (req_data.band_wavelength < lo) lo = req_data.band_wavelength;
                  if (req_data.band_wavelength > hi) hi = req_data.band_wavelength;
               end
               spec_count = n;
               spec_lo = lo;
               spec_hi = hi;
            end else begin
               mean_queue.push_back(resample_band(req_data.center_wavelength,
                                                  req_data.fwhm_width));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (mean_queue.size() == 0) begin
               $display("%0t: unexpected response actual %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               exp_rsp = mean_queue.pop_front();
               if (exp_rsp.result_value !== rsp_data.result_value ||
                   exp_rsp.in_range !== rsp_data.in_range) begin
                  $display("%0t: mismatch expected value %0d in_range %b actual value %0d in_range %b",
                           $time, exp_rsp.result_value, exp_rsp.in_range,
                           rsp_data.result_value, rsp_data.in_range);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= mean_queue.size();
      end
   end

endmodule

### dv/tb_gaussian_band_resampler.sv
// ----------------------------------------------------------------------------
// tb_gaussian_band_resampler
// Loads spectra and issues resampling queries with random gaps and receiver
// stalls, including one long hold-off that fills the request queue.
// ----------------------------------------------------------------------------
module tb_gaussian_band_resampler;
   import gbr_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   gbr_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   gbr_rsp_type rsp_data;
   int          fail_count;
   int          pending_count;
   int          cycle_count;
   logic        hold_off;

   localparam int CYCLE_LIMIT = 3000000;

   gaussian_band_resampler dut (.*);

   gbr_scoreboard scoreboard_inst (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   function automatic gbr_req_type rand_req();
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      return raw[$bits(gbr_req_type)-1:0];
   endfunction

   task automatic send_request(input gbr_req_type r);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         req_data <= rand_req();
         repeat (g) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_band(input logic first, input logic [WL_W-1:0] wl,
                            input logic [SMP_W-1:0] s);
      gbr_req_type r;
      r = rand_req();
      r.operation = 0;
      r.first_band = first;
      r.band_wavelength = wl;
      r.sample_value = s;
      send_request(r);
   endtask

   task automatic query_band(input logic [WL_W-1:0] c, input logic [FW_W-1:0] f);
      gbr_req_type r;
      r = rand_req();
      r.operation = 1;
      r.first_band = $urandom_range(0, 1);
      r.center_wavelength = c;
      r.fwhm_width = f;
      send_request(r);
   endtask

   // receiver stalls, with one long hold-off window
   initial begin
      rsp_ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 0;
            @(negedge clock);
         end else if ($urandom_range(0, 30) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(10, 80)) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
            @(negedge clock);
         end
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("[gaussian_band_resampler] ERROR");
            $finish;
         end
      end
   end

   initial begin
      int n, base, span_wl, step, fw;
      reset = 1;
      req_valid = 0;
      hold_off = 0;
      req_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed
      query_band(20'd500, 16'd10);
      load_band(1, 20'd0, 24'sh7FFFFF);
      load_band(0, 20'hFFFFF, 24'sh800000);
      query_band(20'h80000, 16'd0);
      query_band(20'h80000, 16'hFFFF);
      query_band(20'h80000, 16'd100);
      query_band(20'h0, 16'd1);
      load_band(1, 20'd1000, 24'sh7FFFFF);
      load_band(0, 20'd1010, 24'sh7FFFFF);
      load_band(0, 20'd1020, 24'sh7FFFFF);
      query_band(20'd1010, 16'd3);
      query_band(20'd1010, 16'd4);
      query_band(20'd1009, 16'd1);
      load_band(1, 20'd1000, 24'sh800000);
      load_band(0, 20'd1200, 24'sh800000);
      query_band(20'd1100, 16'd2);
      query_band(20'd1100, 16'd30);
      // overflow the store
      load_band(1, 20'd0, 24'sd1);
      for (int i = 1; i < MAX_BANDS + 3; i++) load_band(0, 20'(i * 4), 24'($urandom));
      query_band(20'd512, 16'd60);

      // long receiver hold-off while queries pile up
      hold_off = 1;
      fork
         begin
            repeat (30000) @(negedge clock);
            hold_off = 0;
         end
      join_none
      for (int i = 0; i < 8; i++) query_band(20'($urandom_range(0, 1100)), 16'd40);

      // random spectra and queries
      for (int k = 0; k < 22; k++) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         base = (k % 7 == 0) ? $urandom_range(1040000, 1048000) : $urandom_range(0, 900000);
         step = $urandom_range(1, 400);
         for (int i = 0; i < n; i++) begin
            load_band(i == 0, 20'(base + i * step + $urandom_range(0, step / 2)),
                      ($urandom_range(0, 5) == 0) ? 24'($urandom_range(0, 1) ? 24'h7FFFFF
                                                                                  : 24'h800000)
                                                   : 24'($urandom));
         end
         span_wl = n * step;
         for (int j = 0; j < 5; j++) begin
            fw = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, span_wl / 3 + 2);
            query_band(20'(base + $urandom_range(0, span_wl)), 16'(fw));
         end
         if ($urandom_range(0, 3) == 0) query_band(20'($urandom), 16'($urandom));
      end

      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("[gaussian_band_resampler] OK");
      end else begin
         $display("[gaussian_band_resampler] ERROR");
      end
      $finish;
   end

endmodule

### files.f
design/gbr_pkg.sv
design/gbr_front.sv
design/gbr_queue.sv
design/gbr_back.sv
design/gaussian_band_resampler.sv
design/gbr_checker.sv
dv/gbr_checker.sv
dv/tb_gaussian_band_resampler.sv
